// ===== sv/bcwq_pkg.sv =====
`default_nettype none

package bcwq_pkg;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_INVALID = 2'd1,
        STATUS_FULL    = 2'd2,
        STATUS_NOMATCH = 2'd3
    } status_t;

    localparam logic FUNC_BLOCK   = 1'b0;
    localparam logic FUNC_UNBLOCK = 1'b1;

    localparam int CLIENT_W = 16;
    localparam int REF_W    = 32;
    localparam int KIND_W   = 4;
    localparam int COUNT_W  = 6;

    typedef struct packed {
        logic [CLIENT_W-1:0] client;
        logic [REF_W-1:0]    storage_ref;
        logic [KIND_W-1:0]   kind;
    } entry_t;

endpackage

`default_nettype wire

// ===== sv/blocked_client_wait_queue_core.sv =====
`default_nettype none

// Ordered wait queue of blocked clients held as a linked list in two
// single-port-read memories (entry data and next-slot links) with a registered
// read. A block request goes through S_BLOCK, and also through S_POP (one extra
// link read) once slots are being reused from the free list. An unblock request
// goes through S_UNBLK and walks the list from the oldest entry in S_WALK up to
// the first match, which S_FREE releases, or to the last entry when nothing
// matches: the walk reads one entry per cycle, following the next-slot links.
// One request is in work at a time; a new request is taken while the previous
// result still waits in the output register.
module blocked_client_wait_queue_core #(
    parameter int CAPACITY = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          func,
    input  wire logic                          client_present,
    input  wire logic [bcwq_pkg::CLIENT_W-1:0] client_id,
    input  wire logic [bcwq_pkg::REF_W-1:0]    storage_ref,
    input  wire logic [bcwq_pkg::KIND_W-1:0]   notify_kind,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [1:0]                         status,
    output logic [bcwq_pkg::CLIENT_W-1:0]      unblocked_client,
    output logic [bcwq_pkg::COUNT_W-1:0]       blocked_count
);

    localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OCC_W  = $clog2(CAPACITY + 1);
    localparam logic [OCC_W-1:0] CAP_OCC = OCC_W'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BLOCK,
        S_POP,
        S_UNBLK,
        S_WALK,
        S_FREE
    } state_t;

    state_t state_reg, state_next;

    logic                          present_reg, present_next;
    logic [bcwq_pkg::CLIENT_W-1:0] id_reg, id_next;
    logic [bcwq_pkg::REF_W-1:0]    ref_reg, ref_next;
    logic [bcwq_pkg::KIND_W-1:0]   kind_reg, kind_next;

    logic [SLOT_W-1:0] head_reg, head_next;
    logic [SLOT_W-1:0] tail_reg, tail_next;
    logic [SLOT_W-1:0] free_head_reg, free_head_next;
    logic [SLOT_W-1:0] cur_reg, cur_next;
    logic [SLOT_W-1:0] prev_reg, prev_next;
    logic [OCC_W-1:0]  occ_reg, occ_next;
    logic [OCC_W-1:0]  fresh_reg, fresh_next;
    logic [OCC_W-1:0]  n_reg, n_next;
    logic [bcwq_pkg::CLIENT_W-1:0] hit_client_reg, hit_client_next;

    logic                          out_valid_reg, out_valid_next;
    bcwq_pkg::status_t             status_reg, status_next;
    logic [bcwq_pkg::CLIENT_W-1:0] client_out_reg, client_out_next;
    logic [bcwq_pkg::COUNT_W-1:0]  count_reg, count_next;

    // memories
    bcwq_pkg::entry_t  data_mem [CAPACITY];
    logic [SLOT_W-1:0] link_mem [CAPACITY];
    bcwq_pkg::entry_t  data_rdata;
    logic [SLOT_W-1:0] link_rdata;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              data_we;
    logic [SLOT_W-1:0] data_waddr;
    bcwq_pkg::entry_t  data_wdata;
    logic              link_we;
    logic [SLOT_W-1:0] link_waddr;
    logic [SLOT_W-1:0] link_wdata;

    logic                          can_emit;
    logic                          hit;
    logic                          do_append;
    logic [SLOT_W-1:0]             append_slot;
    logic                          emit_en;
    bcwq_pkg::status_t             emit_status;
    logic [bcwq_pkg::CLIENT_W-1:0] emit_client;
    logic [OCC_W-1:0]              emit_count;
    logic [OCC_W+bcwq_pkg::COUNT_W-1:0] count_ext;

    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            data_mem[data_waddr] <= data_wdata;
        end
        if (rd_en)
        begin
            data_rdata <= data_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (rd_en)
        begin
            link_rdata <= link_mem[rd_addr];
        end
    end

    assign can_emit = !out_valid_reg || out_ready;
    assign hit = (data_rdata.storage_ref == ref_reg) && (data_rdata.kind == kind_reg);
    assign data_wdata = '{client: id_reg, storage_ref: ref_reg, kind: kind_reg};
    assign count_ext = {{bcwq_pkg::COUNT_W{1'b0}}, emit_count};

    always_comb
    begin
        state_next      = state_reg;
        present_next    = present_reg;
        id_next         = id_reg;
        ref_next        = ref_reg;
        kind_next       = kind_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        free_head_next  = free_head_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        occ_next        = occ_reg;
        fresh_next      = fresh_reg;
        n_next          = n_reg;
        hit_client_next = hit_client_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        status_next     = status_reg;
        client_out_next = client_out_reg;
        count_next      = count_reg;

        rd_en       = 1'b0;
        rd_addr     = cur_reg;
        data_we     = 1'b0;
        data_waddr  = tail_reg;
        link_we     = 1'b0;
        link_waddr  = tail_reg;
        link_wdata  = cur_reg;
        do_append   = 1'b0;
        append_slot = free_head_reg;
        emit_en     = 1'b0;
        emit_status = bcwq_pkg::STATUS_OK;
        emit_client = '0;
        emit_count  = occ_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    present_next = client_present;
                    id_next      = client_id;
                    ref_next     = storage_ref;
                    kind_next    = notify_kind;
                    state_next   = (func == bcwq_pkg::FUNC_UNBLOCK) ? S_UNBLK : S_BLOCK;
                end
            end
            S_BLOCK:
            begin
                if (!present_reg || occ_reg == CAP_OCC)
                begin
                    if (can_emit)
                    begin
                        emit_en     = 1'b1;
                        emit_status = present_reg ? bcwq_pkg::STATUS_FULL
                                                  : bcwq_pkg::STATUS_INVALID;
                        state_next  = S_IDLE;
                    end
                end
                else if (fresh_reg < CAP_OCC)
                begin
                    // never-used slots go out first
                    if (can_emit)
                    begin
                        do_append   = 1'b1;
                        append_slot = fresh_reg[SLOT_W-1:0];
                        fresh_next  = fresh_reg + 1'b1;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = free_head_reg;
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                if (can_emit)
                begin
                    do_append      = 1'b1;
                    append_slot    = free_head_reg;
                    free_head_next = link_rdata;
                    state_next     = S_IDLE;
                end
            end
            S_UNBLK:
            begin
                if (occ_reg == '0)
                begin
                    if (can_emit)
                    begin
                        emit_en     = 1'b1;
                        emit_status = bcwq_pkg::STATUS_NOMATCH;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = head_reg;
                    cur_next   = head_reg;
                    prev_next  = head_reg;
                    n_next     = '0;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (hit)
                begin
                    hit_client_next = data_rdata.client;
                    // unlink the match; its slot joins the free list in S_FREE
                    if (n_reg == '0)
                    begin
                        head_next = link_rdata;
                    end
                    else
                    begin
                        link_we    = 1'b1;
                        link_waddr = prev_reg;
                        link_wdata = link_rdata;
                        if (cur_reg == tail_reg)
                        begin
                            tail_next = prev_reg;
                        end
                    end
                    state_next = S_FREE;
                end
                else if (n_reg + 1'b1 == occ_reg)
                begin
                    if (can_emit)
                    begin
                        emit_en     = 1'b1;
                        emit_status = bcwq_pkg::STATUS_NOMATCH;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    prev_next = cur_reg;
                    cur_next  = link_rdata;
                    n_next    = n_reg + 1'b1;
                    rd_en     = 1'b1;
                    rd_addr   = link_rdata;
                end
            end
            S_FREE:
            begin
                if (can_emit)
                begin
                    link_we        = 1'b1;
                    link_waddr     = cur_reg;
                    link_wdata     = free_head_reg;
                    free_head_next = cur_reg;
                    occ_next       = occ_reg - 1'b1;
                    if (occ_reg == OCC_W'(1))
                    begin
                        head_next = '0;
                        tail_next = '0;
                    end
                    emit_en     = 1'b1;
                    emit_client = hit_client_reg;
                    emit_count  = occ_reg - 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (do_append)
        begin
            data_we    = 1'b1;
            data_waddr = append_slot;
            if (occ_reg == '0)
            begin
                head_next = append_slot;
            end
            else
            begin
                link_we    = 1'b1;
                link_waddr = tail_reg;
                link_wdata = append_slot;
            end
            tail_next  = append_slot;
            occ_next   = occ_reg + 1'b1;
            emit_en    = 1'b1;
            emit_count = occ_reg + 1'b1;
        end

        if (emit_en)
        begin
            out_valid_next  = 1'b1;
            status_next     = emit_status;
            client_out_next = emit_client;
            count_next      = count_ext[bcwq_pkg::COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            present_reg    <= 1'b0;
            id_reg         <= '0;
            ref_reg        <= '0;
            kind_reg       <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            free_head_reg  <= '0;
            cur_reg        <= '0;
            prev_reg       <= '0;
            occ_reg        <= '0;
            fresh_reg      <= '0;
            n_reg          <= '0;
            hit_client_reg <= '0;
            out_valid_reg  <= 1'b0;
            status_reg     <= bcwq_pkg::STATUS_OK;
            client_out_reg <= '0;
            count_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            present_reg    <= present_next;
            id_reg         <= id_next;
            ref_reg        <= ref_next;
            kind_reg       <= kind_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            free_head_reg  <= free_head_next;
            cur_reg        <= cur_next;
            prev_reg       <= prev_next;
            occ_reg        <= occ_next;
            fresh_reg      <= fresh_next;
            n_reg          <= n_next;
            hit_client_reg <= hit_client_next;
            out_valid_reg  <= out_valid_next;
            status_reg     <= status_next;
            client_out_reg <= client_out_next;
            count_reg      <= count_next;
        end
    end

    assign in_ready         = (state_reg == S_IDLE);
    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign unblocked_client = client_out_reg;
    assign blocked_count    = count_reg;

endmodule

`default_nettype wire

// ===== sv/bcwq_checker.sv =====
`default_nettype none

module bcwq_checker #(
    parameter int CAPACITY = 32
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  status,
    input wire logic [15:0] unblocked_client,
    input wire logic [5:0]  blocked_count
);

    localparam logic [5:0] CAP_COUNT = 6'(CAPACITY);
    localparam logic       CAP_WIDE  = (CAPACITY >= 64);

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(unblocked_client) && $stable(blocked_count))
        else $error("result changed while stalled");

    // a refused or missed request removes nobody
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != bcwq_pkg::STATUS_OK |-> unblocked_client == '0)
        else $error("client reported on a failed request");

    // a full refusal means every entry is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == bcwq_pkg::STATUS_FULL |-> blocked_count == CAP_COUNT)
        else $error("full status with free entries");

    // occupancy never exceeds the queue size
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> CAP_WIDE || blocked_count <= CAP_COUNT)
        else $error("count beyond capacity");

endmodule

bind blocked_client_wait_queue_core bcwq_checker #(
    .CAPACITY(CAPACITY)
) u_bcwq_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .unblocked_client (unblocked_client),
    .blocked_count    (blocked_count)
);

`default_nettype wire

// ===== sim/tb_blocked_client_wait_queue_core.sv =====
`timescale 1ns / 1ps

module tb_blocked_client_wait_queue_core;

    localparam int CAPACITY     = 32;
    localparam int SETTLE_CYCLES = 2 * CAPACITY + 8;
    localparam int PHASES       = 10;
    localparam int PHASE_LEN    = 60;

    typedef struct {
        logic                          func;
        logic                          present;
        logic [bcwq_pkg::CLIENT_W-1:0] id;
        logic [bcwq_pkg::REF_W-1:0]    sref;
        logic [bcwq_pkg::KIND_W-1:0]   kind;
    } request_t;

    typedef struct {
        bcwq_pkg::status_t             status;
        logic [bcwq_pkg::CLIENT_W-1:0] client;
        logic [bcwq_pkg::COUNT_W-1:0]  count;
    } outcome_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic                          func = bcwq_pkg::FUNC_BLOCK;
    logic                          client_present = 1'b0;
    logic [bcwq_pkg::CLIENT_W-1:0] client_id = '0;
    logic [bcwq_pkg::REF_W-1:0]    storage_ref = '0;
    logic [bcwq_pkg::KIND_W-1:0]   notify_kind = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [1:0]                    status;
    logic [bcwq_pkg::CLIENT_W-1:0] unblocked_client;
    logic [bcwq_pkg::COUNT_W-1:0]  blocked_count;

    request_t         pending_q[$];
    outcome_t         expected_q[$];
    bcwq_pkg::entry_t waiters[$];
    request_t         in_flight;

    logic [bcwq_pkg::REF_W-1:0]  ref_pool[4];
    logic [bcwq_pkg::KIND_W-1:0] kind_pool[3];

    int n_total = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_errors = 0;
    int n_parked = 0;
    int n_released = 0;
    int n_full = 0;
    int n_no_client = 0;
    int n_no_match = 0;
    int depth_max = 0;
    int send_gap = 0;
    int send_calm = 0;
    int stall_left = 0;
    int stall_calm = 0;

    blocked_client_wait_queue_core #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .client_present  (client_present),
        .client_id       (client_id),
        .storage_ref     (storage_ref),
        .notify_kind     (notify_kind),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .unblocked_client(unblocked_client),
        .blocked_count   (blocked_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Wait queue kept in arrival order; an unblock drops the oldest match.
    function automatic outcome_t wait_queue_step(request_t r);
        outcome_t         o;
        bcwq_pkg::entry_t e;
        int               hit;
        o.status = bcwq_pkg::STATUS_OK;
        o.client = '0;
        hit = -1;
        if (r.func == bcwq_pkg::FUNC_BLOCK)
        begin
            if (!r.present)
            begin
                o.status = bcwq_pkg::STATUS_INVALID;
                n_no_client++;
            end
            else if (waiters.size() >= CAPACITY)
            begin
                o.status = bcwq_pkg::STATUS_FULL;
                n_full++;
            end
            else
            begin
                e.client      = r.id;
                e.storage_ref = r.sref;
                e.kind        = r.kind;
                waiters.push_back(e);
                n_parked++;
            end
        end
        else
        begin
            for (int i = 0; i < waiters.size(); i++)
                if (hit < 0 && waiters[i].storage_ref == r.sref
                        && waiters[i].kind == r.kind)
                    hit = i;
            if (hit < 0)
            begin
                o.status = bcwq_pkg::STATUS_NOMATCH;
                n_no_match++;
            end
            else
            begin
                o.client = waiters[hit].client;
                waiters.delete(hit);
                n_released++;
            end
        end
        if (waiters.size() > depth_max)
            depth_max = waiters.size();
        o.count = bcwq_pkg::COUNT_W'(waiters.size());
        return o;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 96)
            return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic logic [bcwq_pkg::REF_W-1:0] pick_ref();
        logic [bcwq_pkg::REF_W-1:0] v;
        if ($urandom_range(99) < 85)
            v = ref_pool[$urandom_range(3)];
        else
            v = $urandom;
        return v;
    endfunction

    function automatic logic [bcwq_pkg::KIND_W-1:0] pick_kind();
        logic [bcwq_pkg::KIND_W-1:0] v;
        if ($urandom_range(99) < 80)
            v = kind_pool[$urandom_range(2)];
        else
            v = bcwq_pkg::KIND_W'($urandom_range(15));
        return v;
    endfunction

    task automatic add_request(logic f, logic p, logic [bcwq_pkg::CLIENT_W-1:0] id,
                               logic [bcwq_pkg::REF_W-1:0] sref,
                               logic [bcwq_pkg::KIND_W-1:0] kind);
        request_t r;
        r.func    = f;
        r.present = p;
        r.id      = id;
        r.sref    = sref;
        r.kind    = kind;
        pending_q.push_back(r);
    endtask

    task automatic report_mismatch(string msg);
        n_errors++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Request driver: take pending requests in order, idle between them at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid       <= 1'b0;
            func           <= bcwq_pkg::FUNC_BLOCK;
            client_present <= 1'b0;
            client_id      <= '0;
            storage_ref    <= '0;
            notify_kind    <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_q.push_back(wait_queue_step(in_flight));
                n_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    in_flight = pending_q.pop_front();
                    in_valid       <= 1'b1;
                    func           <= in_flight.func;
                    client_present <= in_flight.present;
                    client_id      <= in_flight.id;
                    storage_ref    <= in_flight.sref;
                    notify_kind    <= in_flight.kind;
                    if (send_calm > 0)
                    begin
                        send_calm--;
                        send_gap = 0;
                    end
                    else
                    begin
                        send_gap = pick_gap();
                        if ($urandom_range(49) == 0)
                            send_calm = $urandom_range(80, 30);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare against the oldest expectation, stall at random.
    always @(posedge clk or negedge rst_n)
    begin : result_check
        outcome_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    report_mismatch($sformatf(
                        "unexpected result status %0d client %0h count %0d",
                        status, unblocked_client, blocked_count));
                end
                else
                begin
                    want = expected_q.pop_front();
                    n_results++;
                    if (status !== want.status)
                        report_mismatch($sformatf("result %0d status %0d, want %0d",
                                                  n_results, status, want.status));
                    if (unblocked_client !== want.client)
                        report_mismatch($sformatf("result %0d client %0h, want %0h",
                                                  n_results, unblocked_client, want.client));
                    if (blocked_count !== want.count)
                        report_mismatch($sformatf("result %0d count %0d, want %0d",
                                                  n_results, blocked_count, want.count));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (stall_calm > 0)
                begin
                    stall_calm--;
                end
                else
                begin
                    stall_left = pick_gap();
                    if ($urandom_range(49) == 0)
                        stall_calm = $urandom_range(80, 30);
                end
            end
        end
    end

    initial
    begin
        logic [bcwq_pkg::REF_W-1:0] ra;
        logic                       to_block;
        int                         block_pct;

        ref_pool[0]  = '0;
        ref_pool[1]  = '1;
        ref_pool[2]  = $urandom;
        ref_pool[3]  = $urandom;
        kind_pool[0] = '0;
        kind_pool[1] = '1;
        kind_pool[2] = bcwq_pkg::KIND_W'($urandom_range(14, 1));
        ra = ref_pool[2];

        // directed: empty queue, missing client, duplicates, head/middle/tail removal
        add_request(bcwq_pkg::FUNC_UNBLOCK, 1'b1, 16'h0000, 32'h0000_0000, 4'h0);
        add_request(bcwq_pkg::FUNC_BLOCK,   1'b0, 16'hFFFF, 32'hFFFF_FFFF, 4'hF);
        add_request(bcwq_pkg::FUNC_BLOCK,   1'b1, 16'h0000, 32'h0000_0000, 4'h0);
        add_request(bcwq_pkg::FUNC_BLOCK,   1'b1, 16'hFFFF, 32'hFFFF_FFFF, 4'hF);
        add_request(bcwq_pkg::FUNC_BLOCK,   1'b1, 16'h1234, ra, 4'h3);
        add_request(bcwq_pkg::FUNC_BLOCK,   1'b1, 16'h2222, ra, 4'h3);
        add_request(bcwq_pkg::FUNC_BLOCK,   1'b1, 16'h3333, ra, 4'h5);
        add_request(bcwq_pkg::FUNC_UNBLOCK, 1'b0, 16'h5A5A, ra, 4'h3);
        add_request(bcwq_pkg::FUNC_UNBLOCK, 1'b1, 16'hFFFF, ra, 4'h3);
        add_request(bcwq_pkg::FUNC_UNBLOCK, 1'b1, 16'h0000, ra, 4'h3);
        add_request(bcwq_pkg::FUNC_UNBLOCK, 1'b0, 16'h0000, ra, 4'h5);
        add_request(bcwq_pkg::FUNC_BLOCK,   1'b1, 16'h4444, ra, 4'h3);
        add_request(bcwq_pkg::FUNC_UNBLOCK, 1'b1, 16'h0000, 32'h0000_0000, 4'hF);
        add_request(bcwq_pkg::FUNC_UNBLOCK, 1'b1, 16'h0000, 32'h0000_0000, 4'h0);
        add_request(bcwq_pkg::FUNC_UNBLOCK, 1'b1, 16'h0000, 32'hFFFF_FFFF, 4'hF);
        add_request(bcwq_pkg::FUNC_UNBLOCK, 1'b1, 16'h0000, ra, 4'h3);
        add_request(bcwq_pkg::FUNC_UNBLOCK, 1'b1, 16'h0000, ra, 4'h3);
        add_request(bcwq_pkg::FUNC_BLOCK,   1'b0, 16'h0000, 32'h0000_0000, 4'h0);

        // random: alternate filling and draining phases so the queue hits full and empty
        for (int p = 0; p < PHASES; p++)
        begin
            block_pct = (p % 2 == 0) ? 85 : 20;
            for (int i = 0; i < PHASE_LEN; i++)
            begin
                to_block = ($urandom_range(99) < block_pct);
                if (to_block)
                    add_request(bcwq_pkg::FUNC_BLOCK, $urandom_range(19) != 0,
                                bcwq_pkg::CLIENT_W'($urandom),
                                pick_ref(), pick_kind());
                else
                    add_request(bcwq_pkg::FUNC_UNBLOCK, 1'($urandom_range(1)),
                                bcwq_pkg::CLIENT_W'($urandom),
                                pick_ref(), pick_kind());
            end
        end
        n_total = pending_q.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (n_accepted < n_total || expected_q.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("requests %0d, results %0d: %0d clients parked, %0d released, deepest %0d",
                 n_accepted, n_results, n_parked, n_released, depth_max);
        $display("refusals: %0d full, %0d without client; %0d unblocks found no waiter",
                 n_full, n_no_client, n_no_match);
        if (n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d of %0d requests taken, %0d results pending",
                 n_accepted, n_total, expected_q.size());
        $display("FAILURE");
        $finish;
    end

endmodule
